// ----- hdl/tcsw_pkg.sv -----
`default_nettype none

package tcsw_pkg;

    localparam int COLUMNS = 64;
    localparam int ROWS    = 24;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int FILL_W = $clog2(COLUMNS + 1);
    localparam int LINE_W = $clog2(ROWS + 1);
    localparam int PHYS_W = $clog2(ROWS);
    localparam int ADDR_W = $clog2(ROWS * COLUMNS);

    localparam logic [7:0] CODE_CR    = 8'd13;
    localparam logic [7:0] CODE_LF    = 8'd10;
    localparam logic [7:0] CODE_SPACE = 8'h20;

    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [5:0] read_col;
    } tcsw_in_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [5:0] cursor_col;
        logic [4:0] cursor_row;
        logic       scrolled;
    } tcsw_out_t;

    // Commands from the controller to the datapath, one step each.
    typedef struct packed {
        logic load;
        logic calc;
        logic access;
        logic emit;
    } tcsw_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/tcsw_ctrl.sv -----
`default_nettype none

module tcsw_ctrl
    import tcsw_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire logic  out_ready,
    output tcsw_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_CALC   = 4'b0010,
        S_ACCESS = 4'b0100,
        S_EMIT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CALC;
                end
            end
            S_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = S_ACCESS;
            end
            S_ACCESS:
            begin
                cmd.access = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/tcsw_dpath.sv -----
`default_nettype none

module tcsw_dpath
    import tcsw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tcsw_cmd_t cmd,
    input  wire tcsw_in_t  in_data,
    output tcsw_out_t      out_data
);

    // Architectural state
    logic [PHYS_W-1:0] top_reg, top_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    // Per physical row: columns written since the row was last cleared.
    logic [FILL_W-1:0] fill_reg [ROWS];
    logic [7:0]        screen_mem [ROWS * COLUMNS];

    // Item and step registers
    tcsw_in_t          item_reg;
    logic [PHYS_W-1:0] phys_reg, phys_next;
    logic [COL_W-1:0]  csel_reg, csel_next;
    logic              wr_reg, wr_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              scroll_reg, scroll_next;
    logic [7:0]        rdata_reg;
    logic              hit_reg;
    tcsw_out_t         out_reg;

    logic              is_read, is_cr, is_lf, is_write, do_scroll;
    logic [PHYS_W-1:0] top_w;
    logic [LINE_W-1:0] line_w;
    logic [PHYS_W:0]   sum_w;
    logic [PHYS_W-1:0] base_row;
    logic [ADDR_W-1:0] addr;

    assign is_read   = (item_reg.cmd == CMD_READ);
    assign is_cr     = (item_reg.char_code == CODE_CR);
    assign is_lf     = (item_reg.char_code == CODE_LF);
    assign is_write  = !is_read && !is_cr && !is_lf;
    assign do_scroll = (line_reg >= LINE_W'(ROWS));

    always_comb
    begin
        top_next    = top_reg;
        col_next    = col_reg;
        line_next   = line_reg;
        phys_next   = phys_reg;
        csel_next   = csel_reg;
        wr_next     = 1'b0;
        rd_ok_next  = 1'b0;
        scroll_next = 1'b0;
        top_w       = top_reg;
        line_w      = line_reg;
        base_row    = '0;
        sum_w       = '0;

        if (is_read)
        begin
            rd_ok_next = (32'(item_reg.read_row) < ROWS) && (32'(item_reg.read_col) < COLUMNS);
            base_row   = rd_ok_next ? PHYS_W'(item_reg.read_row) : '0;
            sum_w      = (PHYS_W + 1)'(top_reg) + (PHYS_W + 1)'(base_row);
            csel_next  = rd_ok_next ? COL_W'(item_reg.read_col) : '0;
        end
        else if (is_cr)
        begin
            col_next = '0;
            if (line_reg < LINE_W'(ROWS))
                line_next = line_reg + 1'b1;
        end
        else if (is_write)
        begin
            if (do_scroll)
            begin
                // advance the ring offset; the old top row becomes the new bottom
                top_w       = (top_reg == PHYS_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                line_w      = LINE_W'(ROWS - 1);
                scroll_next = 1'b1;
            end
            sum_w     = (PHYS_W + 1)'(top_w) + (PHYS_W + 1)'(line_w);
            csel_next = col_reg;
            wr_next   = 1'b1;
            top_next  = top_w;
            if (col_reg == COL_W'(COLUMNS - 1))
            begin
                col_next  = '0;
                line_next = line_w + 1'b1;
            end
            else
            begin
                col_next  = col_reg + 1'b1;
                line_next = line_w;
            end
        end

        if (is_read || is_write)
            phys_next = (sum_w >= (PHYS_W + 1)'(ROWS)) ? PHYS_W'(sum_w - (PHYS_W + 1)'(ROWS))
                                                       : PHYS_W'(sum_w);
    end

    assign addr = ADDR_W'(phys_reg) * ADDR_W'(COLUMNS) + ADDR_W'(csel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg  <= '0;
            col_reg  <= '0;
            line_reg <= '0;
            for (int i = 0; i < ROWS; i++)
                fill_reg[i] <= '0;
        end
        else
        begin
            if (cmd.calc)
            begin
                top_reg  <= top_next;
                col_reg  <= col_next;
                line_reg <= line_next;
            end
            // a write lands on the next free column, so the row fill is col + 1;
            // after a scroll that also drops the row's old contents
            if (cmd.access && wr_reg)
                fill_reg[phys_reg] <= FILL_W'(csel_reg) + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_data;
        if (cmd.calc)
        begin
            phys_reg   <= phys_next;
            csel_reg   <= csel_next;
            wr_reg     <= wr_next;
            rd_ok_reg  <= rd_ok_next;
            scroll_reg <= scroll_next;
        end
        if (cmd.access)
        begin
            if (wr_reg)
                screen_mem[addr] <= item_reg.char_code;
            rdata_reg <= screen_mem[addr];
            hit_reg   <= rd_ok_reg && (FILL_W'(csel_reg) < fill_reg[phys_reg]);
        end
        if (cmd.emit)
        begin
            out_reg.cell_char  <= !is_read ? item_reg.char_code
                                           : (hit_reg ? rdata_reg : CODE_SPACE);
            out_reg.cursor_col <= 6'(col_reg);
            out_reg.cursor_row <= 5'(line_reg);
            out_reg.scrolled   <= scroll_reg;
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ----- hdl/text_console_scroll_writer.sv -----
// Character console, 24 rows by 64 columns, with scroll-up.
//
// Input channel (in_valid/in_ready/in_data): one item per character put or
// cell read. A put writes a character at the cursor and advances it; carriage
// return moves to column 0 of the next row, line feed is ignored. Writing
// while the cursor sits below the last row scrolls the screen up a line.
// A read returns the cell at a logical row and column.
// Output channel (out_valid/out_ready/out_data): exactly one item per input
// item, in order, holding the cell character and the cursor after the item.
//
// Timing: each item walks a four-step controller (load, compute, memory
// access, emit), and a new item is accepted only once the last one has
// been emitted. The single-port screen memory access has a step of its own.
// A scroll costs nothing extra: each row keeps a fill count, and columns at
// or past it read as space, so no row clear pass runs.
//
// Reset: asynchronous, active low. The cursor and ring offset go to zero and
// all row fill counts clear, so the whole screen reads as spaces at once.
// Stall: a result waits in the output register; the next item is still
// accepted and processed, and holds in its emit step until the register frees.

`default_nettype none

module text_console_scroll_writer
    import tcsw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire tcsw_in_t in_data,
    output logic          out_valid,
    input  wire logic     out_ready,
    output tcsw_out_t     out_data
);

    tcsw_cmd_t cmd;

    // sequence the steps and own the handshakes
    tcsw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    // cursor, ring offset, row fill counts, screen memory, output register
    tcsw_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
